// ===== hdl/cluster_gaussian_weights_defines.svh =====
// assertion macros for the cluster gaussian weights block
`ifndef CLUSTER_GAUSSIAN_WEIGHTS_DEFINES_SVH
`define CLUSTER_GAUSSIAN_WEIGHTS_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define CGW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgw check failed");

// next-cycle implication, also checked during reset
`define CGW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cgw check failed");

`endif

// ===== hdl/cgw_pkg.sv =====
// shared types, codes and the exp table for the cluster gaussian weights block
package cgw_pkg;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ACC,
    OP_ACC_LAST
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         cluster;
    logic [3:0]         dim;
    logic signed [15:0] value;
  } qent_t;

  typedef struct packed {
    logic [23:0] scale;
    logic [4:0]  nd;
    logic [4:0]  nc;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SQ,
    ST_ADD,
    ST_EXP,
    ST_WAIT,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic q_pop;
    logic mem_we;
    logic mem_re;
    logic latch_cur;
    logic sq_en;
    logic acc_en;
    logic exp_start;
    logic out_load;
    logic clr;
    logic c_inc;
    logic c_zero;
  } back_ctrl_t;

  localparam int ExpSteps = 256;
  localparam logic [63:0] ExpStepQ32 = 64'd4034748382;

  typedef logic [16:0] exp_tab_t [0:ExpSteps];

  // exp(-k/16) in q1.16, built from a q0.31 recurrence
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] e;
    e = 64'd1 << 31;
    for (int k = 0; k <= ExpSteps; k++) begin
      t[k] = 17'((e + 64'd16384) >> 15);
      e = (e * ExpStepQ32 + 64'd2147483648) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== hdl/cgw_front.sv =====
// front end: accepts items, classifies them and queues the ones with work to do
module cgw_front #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_kind,
  input  logic [3:0]         in_cluster,
  input  logic [3:0]         in_dim,
  input  logic signed [15:0] in_value,
  input  cgw_pkg::cfg_t      cfg,
  output cgw_pkg::qent_t     q_head,
  output logic               q_empty,
  input  logic               q_pop
);
  import cgw_pkg::*;

  qent_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, keep;
  qent_t      ent;

  assign in_full = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_head  = q_r[rd_ptr_r];
  assign accept  = in_push && !in_full;

  always_comb begin
    ent.cluster = in_cluster;
    ent.dim     = in_dim;
    ent.value   = in_value;
    if (!in_kind) begin
      ent.op = OP_LOAD;
      keep   = (32'(in_cluster) < MAX_CLUSTERS) && (32'(in_dim) < MAX_DIMS);
    end else begin
      // components beyond the active dimensions are dropped here
      ent.op = ({1'b0, in_dim} == cfg.nd - 5'd1) ? OP_ACC_LAST : OP_ACC;
      keep   = ({1'b0, in_dim} < cfg.nd);
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept && keep) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop && !q_empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    cnt_nxt = cnt_r + 2'(accept && keep) - 2'(q_pop && !q_empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q_r[wr_ptr_r] <= ent;
    end
  end

endmodule

// ===== hdl/cgw_exp.sv =====
// five-stage weight unit: dist * scale, table lookup, linear interpolation
module cgw_exp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [37:0] acc_dist,
  input  logic [23:0] scale,
  output logic        done,
  output logic [15:0] weight
);
  import cgw_pkg::*;

  logic [4:0]  v_r;
  logic [42:0] p_lo_r, p_hi_r;
  logic [61:0] arg_r;
  logic [16:0] hi_r, lo_r, hi2_r;
  logic [15:0] f_r;
  logic        over_r, over2_r;
  logic [32:0] prod_r;
  logic [15:0] w_r;
  logic [7:0]  idx;
  logic [8:0]  idx1;
  logic [16:0] w_full;

  assign idx  = arg_r[51:44];
  assign idx1 = {1'b0, idx} + 9'd1;
  assign w_full = hi2_r - 17'(prod_r >> 16);
  assign done   = v_r[4];
  assign weight = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    // split 38 x 24 into two 19 x 24 products
    p_lo_r  <= 43'(acc_dist[18:0]) * 43'(scale);
    p_hi_r  <= 43'(acc_dist[37:19]) * 43'(scale);
    arg_r   <= {p_hi_r[42:0], 19'b0} + 62'(p_lo_r);
    hi_r    <= EXP_TAB[idx];
    lo_r    <= EXP_TAB[idx1];
    f_r     <= arg_r[43:28];
    over_r  <= (arg_r[61:52] != 10'd0);
    prod_r  <= 33'(hi_r - lo_r) * 33'(f_r);
    hi2_r   <= hi_r;
    over2_r <= over_r;
    if (over2_r) begin
      w_r <= 16'd0;
    end else if (w_full[16]) begin
      w_r <= 16'hFFFF;
    end else begin
      w_r <= w_full[15:0];
    end
  end

endmodule

// ===== hdl/cgw_back.sv =====
// back end: center table, distance accumulators and the per-cluster sequencer
module cgw_back #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cgw_pkg::cfg_t  cfg,
  input  cgw_pkg::qent_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [3:0]     out_cluster_id,
  output logic [15:0]    out_weight,
  output logic           out_last
);
  import cgw_pkg::*;

  localparam int Depth = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [38:0] AccMax = 39'((64'd1 << 38) - 64'd1);

  back_state_t state_r, state_nxt;
  back_ctrl_t  ctrl;

  logic signed [15:0] mem [Depth];
  logic signed [15:0] rdata_r;
  qent_t              cur_r;
  logic [3:0]         c_r;
  logic [31:0]        sq_r;
  logic [37:0]        acc_r [16];
  logic               c_last, out_free;
  logic [AW-1:0]      waddr, raddr;
  logic signed [16:0] diff;
  logic signed [33:0] sq_full;
  logic [38:0]        sum;
  logic               exp_done;
  logic [15:0]        exp_weight;
  logic               out_valid_r;

  assign c_last    = (c_r == 4'(cfg.nc - 5'd1));
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign q_pop     = ctrl.q_pop;
  assign waddr     = AW'(32'(q_head.cluster) * MAX_DIMS + 32'(q_head.dim));
  assign raddr     = AW'(32'(c_r) * MAX_DIMS + 32'(cur_r.dim));
  assign diff      = {cur_r.value[15], cur_r.value} - {rdata_r[15], rdata_r};
  assign sq_full   = diff * diff;
  assign sum       = {1'b0, acc_r[c_r]} + 39'(sq_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty && q_head.op != OP_LOAD) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ADD;
      ST_ADD: begin
        if (!c_last) state_nxt = ST_RD;
        else if (cur_r.op == OP_ACC_LAST) state_nxt = ST_EXP;
        else state_nxt = ST_IDLE;
      end
      ST_EXP:  state_nxt = ST_WAIT;
      ST_WAIT: if (exp_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = c_last ? ST_IDLE : ST_EXP;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.q_pop     = !q_empty;
        ctrl.mem_we    = !q_empty && (q_head.op == OP_LOAD);
        ctrl.latch_cur = !q_empty && (q_head.op != OP_LOAD);
        ctrl.c_zero    = ctrl.latch_cur;
      end
      ST_RD:  ctrl.mem_re = 1'b1;
      ST_SQ:  ctrl.sq_en  = 1'b1;
      ST_ADD: begin
        ctrl.acc_en = 1'b1;
        ctrl.c_inc  = !c_last;
        ctrl.c_zero = c_last;
      end
      ST_EXP: ctrl.exp_start = 1'b1;
      ST_OUT: begin
        ctrl.out_load = out_free;
        ctrl.clr      = out_free && c_last;
        ctrl.c_inc    = out_free && !c_last;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      c_r         <= 4'd0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.c_zero) begin
        c_r <= 4'd0;
      end else if (ctrl.c_inc) begin
        c_r <= c_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_we) begin
      mem[waddr] <= q_head.value;
    end
    if (ctrl.mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_cur) cur_r <= q_head;
    if (ctrl.sq_en) sq_r <= sq_full[31:0];
    if (ctrl.out_load) begin
      out_cluster_id <= c_r;
      out_weight     <= exp_weight;
      out_last       <= c_last;
    end
  end

  // accumulators saturate and are all cleared once a pixel's weights are out
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      for (int i = 0; i < 16; i++) acc_r[i] <= '0;
    end else if (ctrl.acc_en) begin
      acc_r[c_r] <= (sum > AccMax) ? AccMax[37:0] : sum[37:0];
    end
  end

  cgw_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.exp_start),
    .acc_dist (acc_r[c_r]),
    .scale    (cfg.scale),
    .done     (exp_done),
    .weight   (exp_weight)
  );

endmodule

// ===== hdl/cluster_gaussian_weights.sv =====
// top level of the cluster gaussian weights block
// Loads of center components are written from the queue head into the center table
// while the back end is idle. A pixel component leaves the queue and then passes, for
// each active cluster, through the table read, square and accumulate states of the
// back-end sequencer; after the last component of a pixel, each active cluster in turn
// starts the five-stage exp unit, waits while it runs and hands off to the result
// register, stalling while a result waits unread. A two-entry queue lets the front
// accept items while the back works and a result waits.
module cluster_gaussian_weights #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_kind,
  input  logic [3:0]         in_cluster,
  input  logic [3:0]         in_dim,
  input  logic signed [15:0] in_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [3:0]         out_cluster_id,
  output logic [15:0]        out_weight,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cgw_pkg::*;
  `include "cluster_gaussian_weights_defines.svh"

  localparam logic [4:0] NcLim = 5'((MAX_CLUSTERS > 16) ? 16 : MAX_CLUSTERS);
  localparam logic [4:0] NdLim = 5'((MAX_DIMS > 16) ? 16 : MAX_DIMS);
  localparam logic [1:0] RegScale = 2'd0;
  localparam logic [1:0] RegDims  = 2'd1;
  localparam logic [1:0] RegClus  = 2'd2;

  logic [23:0] scale_r;
  logic [4:0]  dims_r, clus_r;
  logic        wr_en;
  cfg_t        cfg;
  qent_t       q_head;
  logic        q_empty, q_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 24'd65536;
      dims_r  <= 5'd1;
      clus_r  <= 5'd1;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegScale: scale_r <= pwdata[23:0];
        RegDims:  dims_r  <= pwdata[4:0];
        RegClus:  clus_r  <= pwdata[4:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegScale: prdata = {8'd0, scale_r};
      RegDims:  prdata = {27'd0, dims_r};
      RegClus:  prdata = {27'd0, clus_r};
      default:  prdata = 32'd0;
    endcase
  end

  // zero counts act as one, large ones clamp to the built limits
  always_comb begin
    cfg.scale = scale_r;
    cfg.nd    = (dims_r == 5'd0) ? 5'd1 : ((dims_r > NdLim) ? NdLim : dims_r);
    cfg.nc    = (clus_r == 5'd0) ? 5'd1 : ((clus_r > NcLim) ? NcLim : clus_r);
  end

  cgw_front #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_kind    (in_kind),
    .in_cluster (in_cluster),
    .in_dim     (in_dim),
    .in_value   (in_value),
    .cfg        (cfg),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop)
  );

  cgw_back #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_cluster_id (out_cluster_id),
    .out_weight     (out_weight),
    .out_last       (out_last)
  );

  `CGW_ASSERT_IMP(a_last_is_final, !out_empty && out_last, out_cluster_id == 4'(cfg.nc - 5'd1))
  `CGW_ASSERT_NEXT(a_reset_empty, !rst_n, out_empty)

endmodule
